// ===== rtl/jsu_pkg.sv =====
// Shared types, character codes, status codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_BUSY      = 4'd0,
    ST_DONE      = 4'd1,
    ST_CTRL_CHAR = 4'd2,
    ST_BAD_ESC   = 4'd3,
    ST_TRUNC     = 4'd4,
    ST_BAD_HEX   = 4'd5,
    ST_BAD_PAIR  = 4'd6,
    ST_UNPAIRED  = 4'd7,
    ST_UNTERM    = 4'd8
  } status_t;

  // Decoder modes, one-hot.
  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b000_0001,
    MODE_PLAIN   = 7'b000_0010,
    MODE_ESC     = 7'b000_0100,
    MODE_HEX1    = 7'b000_1000,
    MODE_WANT_BS = 7'b001_0000,
    MODE_WANT_U  = 7'b010_0000,
    MODE_HEX2    = 7'b100_0000
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] BS_CODE  = 8'h08;
  localparam logic [7:0] FF_CODE  = 8'h0C;
  localparam logic [7:0] LF_CODE  = 8'h0A;
  localparam logic [7:0] CR_CODE  = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Up to four UTF-8 bytes, b0 is sent first.
  typedef struct packed {
    logic [2:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } utf8_t;

  // Hex digit value; bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  function automatic utf8_t encode_utf8(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n  = 3'd1;
      e.b0 = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n  = 3'd2;
      e.b0 = {3'b110, cp[10:6]};
      e.b1 = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n  = 3'd3;
      e.b0 = {4'b1110, cp[15:12]};
      e.b1 = {2'b10, cp[11:6]};
      e.b2 = {2'b10, cp[5:0]};
    end else begin
      e.n  = 3'd4;
      e.b0 = {5'b11110, cp[20:18]};
      e.b1 = {2'b10, cp[17:12]};
      e.b2 = {2'b10, cp[11:6]};
      e.b3 = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== rtl/jsu_channels.sv =====
// Valid/ready channel interfaces for the raw text bytes and the decoded results.
interface jsu_in_if import jsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;
  logic       text_last;

  modport source (output valid, in_byte, string_start, text_last, input ready);
  modport sink (input valid, in_byte, string_start, text_last, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_valid;
  logic [3:0] status;
  logic       last_of_run;

  modport source (output valid, out_byte, data_valid, status, last_of_run, input ready);
  modport sink (input valid, out_byte, data_valid, status, last_of_run, output ready);
endinterface

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// Top level: JSON string body unescaper producing UTF-8 bytes with a status per input byte.
//
//   Channel   Direction  Payload                                      Accepted when
//   in_ch     in         in_byte[8], string_start, text_last          valid && ready
//   out_ch    out        out_byte[8], data_valid, status[4], last     valid && ready
//
// Each accepted item is decoded in the cycle it is taken and its results (one to
// four) are loaded into a four-entry result buffer, which is drained one result per
// cycle while the output is ready. The input is held off while more than one result
// remains in the buffer, since the result buffer has a single output port.
// The next item is taken in the same cycle the last buffered result leaves.
// Bytes ignored while idle are taken without a result.
// Reset (rst_n low, synchronous) empties the buffer and puts the decoder in idle.
// A stalled output simply holds the buffer; no result is lost or repeated.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  // Decoder state.
  mode_t       mode_r, mode_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        pbh_r, pbh_nxt;

  // Result buffer.
  logic        bv_r;
  logic [2:0]  rem_r;
  logic [7:0]  byte_r [4];
  logic        dv_r;
  status_t     st_r;

  // Values after a possible string start.
  mode_t       mode_eff;
  logic [2:0]  hc_eff;
  logic [15:0] acc_eff;
  logic [9:0]  hs_eff;
  logic        pbh_eff;

  logic        produce;
  status_t     st_nxt;
  utf8_t       enc;
  logic [4:0]  nib;
  logic        in_acc;
  logic        out_take;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_take = bv_r && out_ch.ready;

  // The input is free whenever the buffer is empty or its last result leaves now.
  assign in_ch.ready = !bv_r || (out_ch.ready && rem_r == 3'd1);

  assign out_ch.valid       = bv_r;
  assign out_ch.out_byte    = byte_r[0];
  assign out_ch.data_valid  = dv_r;
  assign out_ch.last_of_run = (rem_r == 3'd1);
  assign out_ch.status      = (rem_r == 3'd1) ? st_r : ST_BUSY;

  always_comb begin
    if (in_ch.string_start) begin
      mode_eff = MODE_PLAIN;
      hc_eff   = '0;
      acc_eff  = '0;
      hs_eff   = '0;
      pbh_eff  = 1'b0;
    end else begin
      mode_eff = mode_r;
      hc_eff   = hc_r;
      acc_eff  = acc_r;
      hs_eff   = hs_r;
      pbh_eff  = pbh_r;
    end

    mode_nxt = mode_eff;
    hc_nxt   = hc_eff;
    acc_nxt  = acc_eff;
    hs_nxt   = hs_eff;
    pbh_nxt  = pbh_eff;
    st_nxt   = ST_BUSY;
    enc      = '0;
    produce  = (mode_eff != MODE_IDLE);
    nib      = hex_nibble(in_ch.in_byte);

    case (mode_eff)
      MODE_PLAIN: begin
        if (in_ch.in_byte == CH_QUOTE) begin
          st_nxt = ST_DONE;
        end else if (in_ch.in_byte < CH_SPACE) begin
          st_nxt = ST_CTRL_CHAR;
        end else if (in_ch.in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          enc.n  = 3'd1;
          enc.b0 = in_ch.in_byte;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        enc.n    = 3'd1;
        case (in_ch.in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: enc.b0 = in_ch.in_byte;
          CH_B: enc.b0 = BS_CODE;
          CH_F: enc.b0 = FF_CODE;
          CH_N: enc.b0 = LF_CODE;
          CH_R: enc.b0 = CR_CODE;
          CH_T: enc.b0 = TAB_CODE;
          CH_U: begin
            enc.n    = 3'd0;
            mode_nxt = MODE_HEX1;
            hc_nxt   = '0;
            acc_nxt  = '0;
            pbh_nxt  = 1'b0;
          end
          default: begin
            enc.n  = 3'd0;
            st_nxt = ST_BAD_ESC;
          end
        endcase
      end
      MODE_WANT_BS: begin
        if (in_ch.in_byte == CH_BSLASH) mode_nxt = MODE_WANT_U;
        else st_nxt = ST_BAD_PAIR;
      end
      MODE_WANT_U: begin
        if (in_ch.in_byte == CH_U) begin
          mode_nxt = MODE_HEX2;
          hc_nxt   = '0;
          acc_nxt  = '0;
          pbh_nxt  = 1'b0;
        end else begin
          st_nxt = ST_BAD_PAIR;
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        // A bad digit counts as zero and is only reported at the fourth digit.
        acc_nxt = {acc_eff[11:0], (nib[4] ? 4'h0 : nib[3:0])};
        pbh_nxt = pbh_eff | nib[4];
        hc_nxt  = hc_eff + 3'd1;
        if (hc_eff == 3'd3) begin
          hc_nxt = '0;
          if (pbh_nxt) begin
            st_nxt = ST_BAD_HEX;
          end else if (mode_eff == MODE_HEX1) begin
            if (acc_nxt inside {[16'hD800:16'hDBFF]}) begin
              hs_nxt   = acc_nxt[9:0];
              mode_nxt = MODE_WANT_BS;
            end else if (acc_nxt inside {[16'hDC00:16'hDFFF]}) begin
              st_nxt = ST_UNPAIRED;
            end else begin
              enc      = encode_utf8({5'd0, acc_nxt});
              mode_nxt = MODE_PLAIN;
            end
          end else begin
            if (!(acc_nxt inside {[16'hDC00:16'hDFFF]})) begin
              st_nxt = ST_BAD_PAIR;
            end else begin
              enc      = encode_utf8(SUPP_BASE + {1'b0, hs_eff, acc_nxt[9:0]});
              mode_nxt = MODE_PLAIN;
            end
          end
        end
      end
      default: ;
    endcase

    // End of text while still busy.
    if (st_nxt == ST_BUSY && in_ch.text_last) begin
      case (mode_nxt)
        MODE_PLAIN, MODE_ESC: st_nxt = ST_UNTERM;
        MODE_HEX1, MODE_HEX2: st_nxt = ST_TRUNC;
        default:              st_nxt = ST_BAD_PAIR;
      endcase
    end

    // Any final status ends the string.
    if (st_nxt != ST_BUSY) begin
      mode_nxt = MODE_IDLE;
      hc_nxt   = '0;
      acc_nxt  = '0;
      hs_nxt   = '0;
      pbh_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hc_r   <= '0;
      acc_r  <= '0;
      hs_r   <= '0;
      pbh_r  <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
      pbh_r  <= pbh_nxt;
    end
  end

  // Result buffer: loads all results of an item at once, then shifts one out per take.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      rem_r <= '0;
    end else if (in_acc && produce) begin
      bv_r  <= 1'b1;
      rem_r <= (enc.n == 3'd0) ? 3'd1 : enc.n;
    end else if (out_take) begin
      if (rem_r == 3'd1) bv_r <= 1'b0;
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      byte_r[0] <= enc.b0;
      byte_r[1] <= enc.b1;
      byte_r[2] <= enc.b2;
      byte_r[3] <= enc.b3;
      dv_r      <= (enc.n != 3'd0);
      st_r      <= st_nxt;
    end else if (out_take) begin
      byte_r[0] <= byte_r[1];
      byte_r[1] <= byte_r[2];
      byte_r[2] <= byte_r[3];
    end
  end

  // A result without data is always the only result of its item.
  a_nodata_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data_valid |-> out_ch.last_of_run)
    else $error("result without data is not the last of its item");

  // Results before the last one of an item carry data and busy status.
  a_early_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_run |-> out_ch.data_valid && out_ch.status == ST_BUSY)
    else $error("early result carries a final status or no data");

  // Input is held off while more than one result remains buffered.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    bv_r && rem_r > 3'd1 |-> !in_ch.ready)
    else $error("input taken while results remain");

  // A final status always returns the decoder to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && produce && st_nxt != ST_BUSY |=> mode_r == MODE_IDLE)
    else $error("decoder not idle after final status");

endmodule
